/* hdl/smft_pkg.sv */
// Shared constants, status codes and the control word type for the sorted
// multiset floor-take block. No dependencies.
`timescale 1ns / 1ps

package smft_pkg;

  localparam int DEPTH   = 256;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int GROUP   = 16;
  localparam int NGROUPS = (DEPTH + GROUP - 1) / GROUP;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_TAKEN    = 2'd1;
  localparam logic [1:0] ST_NONE     = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_TAKE   = 1'b1;

  // Broadcast control word seen by every cell of the chain.
  typedef struct packed {
    logic             cmp;
    logic             ins;
    logic             take;
    logic [VAL_W-1:0] key;
  } smft_ctl_t;

endpackage

/* hdl/smft_cell.sv */
// One cell of the sorted chain: holds one entry and its compare flag.
// Depends on smft_pkg.
`timescale 1ns / 1ps

module smft_cell import smft_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  smft_ctl_t        ctl,
  input  logic             occ,
  input  logic             left_le,
  input  logic [VAL_W-1:0] left_value,
  input  logic             right_le,
  input  logic [VAL_W-1:0] right_value,
  output logic             le,
  output logic [VAL_W-1:0] value,
  output logic [VAL_W-1:0] hit_value
);

  always_ff @(posedge clk) begin
    if (rst) begin
      le <= 1'b0;
    end else if (ctl.cmp) begin
      le <= occ && (value <= ctl.key);
    end
  end

  // An insert opens a gap at the first cell above the key; a take closes the
  // gap left by the floor entry by pulling from the right.
  always_ff @(posedge clk) begin
    if (ctl.ins && !le) begin
      value <= left_le ? ctl.key : left_value;
    end else if (ctl.take && !(le && right_le)) begin
      value <= right_value;
    end
  end

  assign hit_value = (ctl.take && le && !right_le) ? value : '0;

endmodule

/* hdl/sorted_multiset_floor_take.sv */
// Top level of the sorted multiset with floor-take: the cell chain, the
// sequencer and the registered OR tree for the removed value.
// Depends on smft_pkg and smft_cell.
`timescale 1ns / 1ps

// Channel  Signals                              Direction  Meaning
// input    in_valid, in_stall, kind, value      in         insert or take word
// output   out_valid, out_stall, status,        out        one result word
//          taken_value
//
// Every word passes through these steps: accept, a compare cycle in which all cells
// test their entry against the key in parallel, a shift cycle in which the
// chain moves one place and sixteen-cell groups OR their hit values, and a
// final OR over the groups that loads the output register.
// The next word is accepted while a finished result still waits in the
// output register; a stalled output holds the sequencer in its last step.
// Reset empties the store at once through the entry count; cell contents
// are left as they are, since cells at or above the count are never used.

module sorted_multiset_floor_take import smft_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             kind,
  input  logic [VAL_W-1:0] value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [VAL_W-1:0] taken_value
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CMP    = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_REDUCE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic [VAL_W-1:0] key_q;
  logic             take_q;
  logic [1:0]       status_q;

  smft_ctl_t        ctl;
  logic             le     [DEPTH];
  logic [VAL_W-1:0] cell_v [DEPTH];
  logic [VAL_W-1:0] hit_v  [DEPTH];
  logic [VAL_W-1:0] grp    [NGROUPS];
  logic [VAL_W-1:0] grp_next [NGROUPS];
  logic [VAL_W-1:0] final_or;
  logic             accept;
  logic             take_found;
  logic             out_load;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state != S_IDLE);
  assign take_found = take_q && le[0];
  assign out_load   = (state == S_REDUCE) && (!out_valid || !out_stall);

  // A full insert leaves the chain alone; so does a take with nothing at or
  // below the key, which shows up as a clear compare flag in the first cell.
  assign ctl.cmp  = (state == S_CMP);
  assign ctl.ins  = (state == S_SHIFT) && !take_q && (status_q == ST_INSERTED);
  assign ctl.take = (state == S_SHIFT) && take_found;
  assign ctl.key  = key_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             l_le, r_le;
    logic [VAL_W-1:0] l_v, r_v;
    if (i == 0) begin : g_first
      assign l_le = 1'b1;
      assign l_v  = key_q;
    end else begin : g_mid_l
      assign l_le = le[i-1];
      assign l_v  = cell_v[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_le = 1'b0;
      assign r_v  = cell_v[i];
    end else begin : g_mid_r
      assign r_le = le[i+1];
      assign r_v  = cell_v[i+1];
    end
    smft_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .occ         (CNT_W'(i) < count),
      .left_le     (l_le),
      .left_value  (l_v),
      .right_le    (r_le),
      .right_value (r_v),
      .le          (le[i]),
      .value       (cell_v[i]),
      .hit_value   (hit_v[i])
    );
  end

  // At most one cell hits, so a plain OR picks the removed value.
  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      grp_next[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < DEPTH) begin
          grp_next[g] = grp_next[g] | hit_v[g * GROUP + j];
        end
      end
    end
  end

  always_comb begin
    final_or = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      final_or = final_or | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SHIFT) begin
      for (int g = 0; g < NGROUPS; g++) begin
        grp[g] <= grp_next[g];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_CMP;
      S_CMP:    state_next = S_SHIFT;
      S_SHIFT:  state_next = S_REDUCE;
      S_REDUCE: if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (ctl.ins) begin
        count <= count + CNT_W'(1);
      end else if (ctl.take) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_q    <= value;
      take_q   <= (kind == KIND_TAKE);
      status_q <= (kind == KIND_TAKE) ? ST_NONE :
                  ((count == CNT_W'(DEPTH)) ? ST_FULL : ST_INSERTED);
    end else if ((state == S_SHIFT) && take_q) begin
      status_q <= le[0] ? ST_TAKEN : ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= status_q;
      taken_value <= final_or;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_count_only_in_shift: assert property (@(posedge clk) disable iff (rst)
    (state != S_SHIFT) |=> (count == $past(count)))
    else $error("entry count moved outside the shift step");

  a_accept_starts_cmp: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CMP))
    else $error("accepted word did not start a compare");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    ((state == S_REDUCE) && (status_q == ST_FULL)) |-> (count == CNT_W'(DEPTH)))
    else $error("full status while the store has room");

  a_no_take_no_value: assert property (@(posedge clk) disable iff (rst)
    ((state == S_REDUCE) && (status_q != ST_TAKEN)) |-> (final_or == '0))
    else $error("removed value present without a take");

endmodule

/* tb/sorted_multiset_floor_take_tb.sv */
// Self-checking testbench for the sorted multiset floor-take block: a small
// scoreboard class tracks the stored values and the expected result words.
// Depends on smft_pkg and the sorted_multiset_floor_take RTL.
`timescale 1ns / 1ps

import smft_pkg::*;

// Tracks the multiset the block should hold and the result words it owes.
class floor_take_board;
  logic [VAL_W-1:0] held_values[$];
  logic [1:0]       owed_status[$];
  logic [VAL_W-1:0] owed_taken[$];
  int               error_count;

  function new();
    error_count = 0;
  endfunction

  // The held values stay in ascending order, so this is the insert position
  // and one past the floor entry for a take.
  function int count_not_above(logic [VAL_W-1:0] key);
    int n;
    n = 0;
    while (n < held_values.size() && held_values[n] <= key) n++;
    return n;
  endfunction

  function int outstanding();
    return owed_status.size();
  endfunction

  // Applies one accepted word to the tracked store and queues its result.
  function void note_word(logic word_kind, logic [VAL_W-1:0] word_value);
    int               n;
    logic [1:0]       st;
    logic [VAL_W-1:0] tk;
    tk = '0;
    n  = count_not_above(word_value);
    if (word_kind == KIND_INSERT) begin
      if (held_values.size() >= DEPTH) begin
        st = ST_FULL;
      end else begin
        held_values.insert(n, word_value);
        st = ST_INSERTED;
      end
    end else if (n == 0) begin
      st = ST_NONE;
    end else begin
      tk = held_values[n - 1];
      held_values.delete(n - 1);
      st = ST_TAKEN;
    end
    owed_status.push_back(st);
    owed_taken.push_back(tk);
  endfunction

  // Prints one line for each mismatch and counts it.
  task report_mismatch(string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  task check_result(input logic [1:0] got_status, input logic [VAL_W-1:0] got_taken);
    logic [1:0]       exp_status;
    logic [VAL_W-1:0] exp_taken;
    if (owed_status.size() == 0) begin
      report_mismatch($sformatf("unexpected result, status %0d value %h",
                                got_status, got_taken));
      return;
    end
    exp_status = owed_status.pop_front();
    exp_taken  = owed_taken.pop_front();
    if (got_status !== exp_status)
      report_mismatch($sformatf("status %0d, expected %0d", got_status, exp_status));
    if (got_taken !== exp_taken)
      report_mismatch($sformatf("taken_value %h, expected %h", got_taken, exp_taken));
  endtask
endclass

module sorted_multiset_floor_take_tb;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             kind = KIND_INSERT;
  logic [VAL_W-1:0] value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       status;
  logic [VAL_W-1:0] taken_value;

  floor_take_board board = new();

  always #1 clk = ~clk;

  sorted_multiset_floor_take u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .taken_value (taken_value)
  );

  // Offers one word and holds it until the block takes it. The valid is left
  // high so that a following word goes out back to back; only a gap lowers it.
  task send_word(input logic word_kind, input logic [VAL_W-1:0] word_value);
    in_valid <= 1'b1;
    kind     <= word_kind;
    value    <= word_value;
    do @(posedge clk); while (in_stall);
    board.note_word(word_kind, word_value);
  endtask

  task idle_for(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Values lean toward a small range so that duplicates and floor hits are
  // common, with the top of the range and full random words mixed in.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom_range(0, 15);
      2:       return $urandom_range(0, 1) ? '0 : '1;
      3:       return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // Sends a run of random words in bursts. The take share steers the store:
  // a low share fills it up to the full case, a high share drains it down to
  // empty, and an even share keeps it wandering in between.
  task run_phase(input int words, input int take_pct, input int max_gap);
    int   left;
    int   burst;
    logic word_kind;
    left = words;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) begin
        word_kind = ($urandom_range(0, 99) < take_pct) ? KIND_TAKE : KIND_INSERT;
        send_word(word_kind, pick_value());
      end
      left -= burst;
      if (max_gap > 0 && $urandom_range(0, 3) != 0) idle_for($urandom_range(1, max_gap));
    end
  endtask

  // Result side. Each accepted result word goes to the scoreboard. The stall
  // follows a mode that is picked anew at random: never, light random, heavy
  // random, or a regular pattern set by the mode counter. Twice in the run,
  // after the 150th and the 900th result, the receiver holds off while the
  // sender keeps offering, so the block backs up and has to stall its input.
  initial begin : result_side
    int results_seen;
    int hold_left;
    int mode;
    int mode_left;
    results_seen = 0;
    hold_left    = 0;
    mode         = 0;
    mode_left    = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        board.check_result(status, taken_value);
        results_seen++;
        if (results_seen == 150 || results_seen == 900) hold_left = 300;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(40, 160);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed words. Takes on an empty store must report none found, at
    // both ends of the key range.
    send_word(KIND_TAKE, 32'h0000_0000);
    send_word(KIND_TAKE, 32'hFFFF_FFFF);
    // A duplicate pair plus both extremes of the value range.
    send_word(KIND_INSERT, 32'd5);
    send_word(KIND_INSERT, 32'd5);
    send_word(KIND_INSERT, 32'h0000_0000);
    idle_for(2);
    send_word(KIND_INSERT, 32'hFFFF_FFFF);
    send_word(KIND_INSERT, 32'd100);
    // A key just below the duplicates finds zero, then nothing at all.
    send_word(KIND_TAKE, 32'd4);
    send_word(KIND_TAKE, 32'd4);
    // Exact match, then the floor of a larger key takes the second copy.
    send_word(KIND_TAKE, 32'd5);
    send_word(KIND_TAKE, 32'd99);
    send_word(KIND_TAKE, 32'd99);
    idle_for(3);
    send_word(KIND_TAKE, 32'hFFFF_FFFE);
    send_word(KIND_INSERT, 32'hFFFF_FFFE);
    // The top key removes the largest values in turn until the store is empty.
    send_word(KIND_TAKE, 32'hFFFF_FFFF);
    send_word(KIND_TAKE, 32'hFFFF_FFFF);
    send_word(KIND_TAKE, 32'hFFFF_FFFF);
    // Neighbors across the top bit check the unsigned compare.
    send_word(KIND_INSERT, 32'h8000_0000);
    send_word(KIND_INSERT, 32'h7FFF_FFFF);
    send_word(KIND_TAKE, 32'h7FFF_FFFF);
    send_word(KIND_TAKE, 32'h8000_0000);

    // Random words: fill past full, drain past empty, then mixed traffic,
    // once with no gaps at all and once with gaps.
    run_phase(360, 5, 6);
    run_phase(360, 92, 6);
    run_phase(300, 50, 0);
    run_phase(430, 50, 8);
    in_valid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    // The wait below covers any stray late result.
    repeat (16) @(posedge clk);
    if (board.error_count == 0) begin
      $display("sorted_multiset_floor_take_tb: clean");
    end else begin
      $display("sorted_multiset_floor_take_tb: errors");
    end
    $finish;
  end

  // Guards against a hang: far beyond the slowest correct run.
  initial begin : watchdog
    #1000000;
    $display("sorted_multiset_floor_take_tb: errors");
    $finish;
  end

endmodule

/* sorted_multiset_floor_take.f */
hdl/smft_pkg.sv
hdl/smft_cell.sv
hdl/sorted_multiset_floor_take.sv
tb/sorted_multiset_floor_take_tb.sv
